// ===== src/icgr_pkg.sv =====
// Shared types and codes for the icon glyph coverage rasterizer.
package icgr_pkg;

  typedef enum logic [3:0] {
    GLYPH_PLAY        = 4'd0,
    GLYPH_PAUSE       = 4'd1,
    GLYPH_NEXT        = 4'd2,
    GLYPH_PREV        = 4'd3,
    GLYPH_HEART       = 4'd4,
    GLYPH_HEART_RING  = 4'd5,
    GLYPH_HEART_SLASH = 4'd6,
    GLYPH_CHEV_UP     = 4'd7,
    GLYPH_CHEV_DOWN   = 4'd8
  } glyph_kind_t;

  localparam logic [2:0] REG_GLYPH_KIND  = 3'd0;
  localparam logic [2:0] REG_CENTER_X    = 3'd1;
  localparam logic [2:0] REG_CENTER_Y    = 3'd2;
  localparam logic [2:0] REG_HALF_SIZE   = 3'd3;
  localparam logic [2:0] REG_DRAW_COLOR  = 3'd4;
  localparam logic [2:0] REG_BLEND_ALPHA = 3'd5;

  localparam int DEF_SCREEN_WIDTH = 320;
  localparam int DEF_FRAC_BITS    = 16;

  localparam logic [9:0] ALPHA_RESET = 10'd256;
  localparam logic [8:0] ALPHA_FULL  = 9'd256;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } stage_ctl_t;

endpackage

// ===== src/icgr_inv_div.sv =====
// Bit-serial restoring divider: quotient = 2^FRAC_BITS / divisor.
module icgr_inv_div #(
  parameter int FRAC_BITS = icgr_pkg::DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [9:0]           divisor,
  output logic                 busy,
  output logic [FRAC_BITS:0]   quotient
);
  import icgr_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  div_state_t         state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [9:0]         rem, rem_next;
  logic [9:0]         dvs, dvs_next;
  logic [FRAC_BITS:0] quot_next;
  logic [10:0]        rem_sh;
  logic               qbit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= DIV_IDLE;
      count    <= '0;
      rem      <= '0;
      dvs      <= '0;
      quotient <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rem      <= rem_next;
      dvs      <= dvs_next;
      quotient <= quot_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    rem_next   = rem;
    dvs_next   = dvs;
    quot_next  = quotient;
    // dividend is a single one at bit FRAC_BITS
    rem_sh     = {rem, (count == CNT_W'(FRAC_BITS))};
    qbit       = (rem_sh >= {1'b0, dvs});
    busy       = (state == DIV_RUN);
    // a new divisor restarts the division, even mid-run
    if (start) begin
      state_next = DIV_RUN;
      count_next = CNT_W'(FRAC_BITS);
      rem_next   = '0;
      dvs_next   = divisor;
      quot_next  = '0;
    end else begin
      unique case (state)
        DIV_IDLE: ;
        DIV_RUN: begin
          rem_next  = qbit ? 10'(rem_sh - {1'b0, dvs}) : rem_sh[9:0];
          quot_next = {quotient[FRAC_BITS-1:0], qbit};
          if (count == '0) begin
            state_next = DIV_IDLE;
          end else begin
            count_next = count - CNT_W'(1);
          end
        end
        default: state_next = DIV_IDLE;
      endcase
    end
  end

endmodule

// ===== src/icgr_map.sv =====
// Stage 1: box, screen and enable tests, mapping to normalized u, v.
module icgr_map #(
  parameter int SCREEN_WIDTH = icgr_pkg::DEF_SCREEN_WIDTH,
  parameter int FRAC_BITS    = icgr_pkg::DEF_FRAC_BITS,
  parameter int FW           = FRAC_BITS + 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     take,
  input  logic signed [11:0]       pixel_x,
  input  logic signed [11:0]       pixel_y,
  input  logic signed [11:0]       center_x,
  input  logic signed [11:0]       center_y,
  input  logic [9:0]               half_size,
  input  logic                     alpha_on,
  input  logic [FRAC_BITS:0]       inv,
  output icgr_pkg::stage_ctl_t     ctl,
  output logic signed [FW-1:0]     u,
  output logic signed [FW-1:0]     v
);
  import icgr_pkg::*;

  localparam int PW = 13 + FRAC_BITS + 2;

  logic signed [12:0] dx, dy, hs, pxe;
  logic signed [PW-1:0] pu, pv;
  logic in_box, on_screen, ok;

  always_comb begin
    dx        = 13'(pixel_x) - 13'(center_x);
    dy        = 13'(center_y) - 13'(pixel_y);
    hs        = $signed({3'b000, half_size});
    pxe       = 13'(pixel_x);
    in_box    = (dx <= hs) && (dx >= -hs) && (dy <= hs) && (dy >= -hs);
    on_screen = (pxe >= 13'sd0) && (pxe < $signed(13'(SCREEN_WIDTH)));
    ok        = (half_size != '0) && alpha_on && in_box && on_screen;
    pu        = PW'(dx) * $signed(PW'({1'b0, inv}));
    pv        = PW'(dy) * $signed(PW'({1'b0, inv}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl.valid <= take;
      ctl.ok    <= ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u <= FW'(pu);
      v <= FW'(pv);
    end
  end

endmodule

// ===== src/icgr_shape.sv =====
// Stages 2 to 4: shape tests; combinational hit from the last stage.
module icgr_shape #(
  parameter int FRAC_BITS = icgr_pkg::DEF_FRAC_BITS,
  parameter int FW        = FRAC_BITS + 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  icgr_pkg::stage_ctl_t     ctl_in,
  input  logic signed [FW-1:0]     u,
  input  logic signed [FW-1:0]     v,
  input  logic [3:0]               glyph_kind,
  output icgr_pkg::stage_ctl_t     ctl_out,
  output logic                     hit
);
  import icgr_pkg::*;

  localparam int CW = FW + 16;
  localparam longint ONE_L = longint'(1) <<< FRAC_BITS;
  localparam logic signed [2*FW-1:0] QBIAS = (2*FW)'(ONE_L - 1);

  localparam logic signed [FW-1:0] C82   = FW'((82 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C6724 = FW'((6724 * ONE_L + 5000) / 10000);
  localparam logic signed [FW-1:0] C60   = FW'((60 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C36   = FW'((36 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C7071 = FW'((7071 * ONE_L + 5000) / 10000);
  localparam logic signed [FW-1:0] C55   = FW'((55 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C80   = FW'((80 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C16   = FW'((16 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C62   = FW'((62 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C90   = FW'((90 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C18   = FW'((18 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C54   = FW'((54 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C74   = FW'((74 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C92   = FW'((92 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C76   = FW'((76 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C10   = FW'((10 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C85   = FW'((85 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C42   = FW'((42 * ONE_L + 50) / 100);
  localparam logic signed [FW-1:0] C17   = FW'((17 * ONE_L + 50) / 100);

  // fixed-point product, truncated toward zero
  function automatic logic signed [FW-1:0] qm(input logic signed [FW-1:0] a,
                                               input logic signed [FW-1:0] b);
    logic signed [2*FW-1:0] p;
    p = (2*FW)'(a) * (2*FW)'(b);
    if (p < 0) p = p + QBIAS;
    return FW'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [FW-1:0] fabs(input logic signed [FW-1:0] a);
    return (a < 0) ? -a : a;
  endfunction

  // ---- stage 2 ----
  logic signed [FW-1:0] au, av, uu, vv;
  logic signed [CW-1:0] lhs135, rhs_play, lhs72, rhs_n1, rhs_n2;
  logic play_h, pause_h, r1, r2, r3, simple_c;

  stage_ctl_t           c2;
  logic signed [FW-1:0] x2_2, y2_2, v_2, sp_2, chq_2, vv_2;
  logic                 aubig_2, simple_2;

  always_comb begin
    au       = fabs(u);
    av       = fabs(v);
    lhs135   = CW'(av) * CW'(13500);
    rhs_play = CW'(8200) * CW'(C80 - u);
    play_h   = !((u < -C55) || (u > C80)) && (lhs135 <= rhs_play);
    pause_h  = (au >= C16) && (au <= C62) && (av <= C80);
    uu       = (glyph_kind == GLYPH_PREV) ? -u : u;
    vv       = (glyph_kind == GLYPH_CHEV_DOWN) ? -v : v;
    lhs72    = CW'(av) * CW'(7200);
    rhs_n1   = CW'(7600) * CW'(-C18 - uu);
    rhs_n2   = CW'(7600) * CW'(C54 - uu);
    r1       = (uu >= -C90) && (uu <= -C18) && (lhs72 <= rhs_n1);
    r2       = (uu >= -C18) && (uu <= C54) && (lhs72 <= rhs_n2);
    r3       = (uu >= C74) && (uu <= C92) && (av <= C76);
    unique case (glyph_kind)
      GLYPH_PLAY:              simple_c = play_h;
      GLYPH_PAUSE:             simple_c = pause_h;
      GLYPH_NEXT, GLYPH_PREV:  simple_c = r1 || r2 || r3;
      default:                 simple_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x2_2     <= qm(u, u);
      y2_2     <= qm(v, v);
      v_2      <= v;
      sp_2     <= qm(v - u, C7071);
      chq_2    <= qm(au, C85);
      vv_2     <= vv;
      aubig_2  <= (au > C85);
      simple_2 <= simple_c;
    end
  end

  // ---- stage 3 ----
  logic signed [FW-1:0] a1_c, a2_c;
  stage_ctl_t           c3;
  logic signed [FW-1:0] a1_3, a2_3, aa1_3, aa2_3, kx1_3, kx2_3, y3_3;
  logic                 simple_3, slash_3, chev_3;

  always_comb begin
    a1_c = x2_2 + y2_2 - C6724;
    a2_c = x2_2 + y2_2 - C36;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_3     <= a1_c;
      a2_3     <= a2_c;
      aa1_3    <= qm(a1_c, a1_c);
      aa2_3    <= qm(a2_c, a2_c);
      kx1_3    <= qm(C82, x2_2);
      kx2_3    <= qm(C60, x2_2);
      y3_3     <= qm(y2_2, v_2);
      simple_3 <= simple_2;
      slash_3  <= fabs(sp_2) <= C10;
      chev_3   <= !aubig_2 && (fabs(vv_2 - (C42 - chq_2)) <= C17);
    end
  end

  // ---- stage 4 ----
  stage_ctl_t           c4;
  logic signed [FW-1:0] a31_4, a32_4, t1_4, t2_4;
  logic                 simple_4, slash_4, chev_4;

  always_ff @(posedge clk) begin
    if (adv) begin
      a31_4    <= qm(aa1_3, a1_3);
      a32_4    <= qm(aa2_3, a2_3);
      t1_4     <= qm(kx1_3, y3_3);
      t2_4     <= qm(kx2_3, y3_3);
      simple_4 <= simple_3;
      slash_4  <= slash_3;
      chev_4   <= chev_3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
    end else if (adv) begin
      c2 <= ctl_in;
      c3 <= c2;
      c4 <= c3;
    end
  end

  // ---- final decision, registered in the top level ----
  logic h_outer, h_inner, ring, shape_h;

  always_comb begin
    h_outer = ((FW+1)'(a31_4) - (FW+1)'(t1_4)) <= 0;
    h_inner = ((FW+1)'(a32_4) - (FW+1)'(t2_4)) <= 0;
    ring    = h_outer && !h_inner;
    unique case (glyph_kind)
      GLYPH_PLAY, GLYPH_PAUSE,
      GLYPH_NEXT, GLYPH_PREV:          shape_h = simple_4;
      GLYPH_HEART:                     shape_h = h_outer;
      GLYPH_HEART_RING:                shape_h = ring;
      GLYPH_HEART_SLASH:               shape_h = ring || slash_4;
      GLYPH_CHEV_UP, GLYPH_CHEV_DOWN:  shape_h = chev_4;
      default:                         shape_h = 1'b0;
    endcase
    ctl_out = c4;
    hit     = c4.ok && shape_h;
  end

endmodule

// ===== src/icon_glyph_coverage_raster.sv =====
// Icon glyph coverage rasterizer: one pixel request in, one coverage result out.
// A request passes the map stage, three shape stages and the output register
// before its result is valid. Throughput: one pixel per cycle, except while
// result_stall backpressure freezes the whole pipeline or the divider is busy.
// A half_size write starts a 1/half divider, and pixel requests are stalled while
// it runs. Reset (rst, synchronous) empties the pipeline and loads register
// defaults (blend_alpha 256, others 0).
module icon_glyph_coverage_raster #(
  parameter int SCREEN_WIDTH = icgr_pkg::DEF_SCREEN_WIDTH,
  parameter int FRAC_BITS    = icgr_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               write_enable,
  input  logic [2:0]         reg_index,
  input  logic [15:0]        write_data,
  // pixel request channel
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  logic signed [11:0] pixel_x,
  input  logic signed [11:0] pixel_y,
  // coverage result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic               write_pixel,
  output logic               opaque,
  output logic [15:0]        pixel_color,
  output logic [8:0]         blend_weight
);
  import icgr_pkg::*;

  localparam int FW = FRAC_BITS + 5;

  // configuration registers
  logic [3:0]         glyph_kind;
  logic signed [11:0] center_x, center_y;
  logic [9:0]         half_size;
  logic [15:0]        draw_color;
  logic [9:0]         blend_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_kind  <= '0;
      center_x    <= '0;
      center_y    <= '0;
      half_size   <= '0;
      draw_color  <= '0;
      blend_alpha <= ALPHA_RESET;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_GLYPH_KIND:  glyph_kind  <= write_data[3:0];
        REG_CENTER_X:    center_x    <= write_data[11:0];
        REG_CENTER_Y:    center_y    <= write_data[11:0];
        REG_HALF_SIZE:   half_size   <= write_data[9:0];
        REG_DRAW_COLOR:  draw_color  <= write_data;
        REG_BLEND_ALPHA: blend_alpha <= write_data[9:0];
        default: ;
      endcase
    end
  end

  // saturated blend weight
  logic [8:0] weight;
  assign weight = (blend_alpha > 10'(ALPHA_FULL)) ? ALPHA_FULL : blend_alpha[8:0];

  // reciprocal of half_size, recomputed after every half_size write
  logic               div_busy;
  logic [FRAC_BITS:0] inv;

  icgr_inv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (write_enable && (reg_index == REG_HALF_SIZE)),
    .divisor  (write_data[9:0]),
    .busy     (div_busy),
    .quotient (inv)
  );

  // whole pipeline moves together unless a finished result is held
  logic adv, take;
  assign adv         = !(result_valid && result_stall);
  assign pixel_stall = !adv || div_busy;
  assign take        = pixel_valid && !pixel_stall;

  stage_ctl_t           ctl1, ctl4;
  logic signed [FW-1:0] u1, v1;
  logic                 hit4;

  icgr_map #(.SCREEN_WIDTH(SCREEN_WIDTH), .FRAC_BITS(FRAC_BITS), .FW(FW)) u_map (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .take      (take),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .center_x  (center_x),
    .center_y  (center_y),
    .half_size (half_size),
    .alpha_on  (weight != '0),
    .inv       (inv),
    .ctl       (ctl1),
    .u         (u1),
    .v         (v1)
  );

  icgr_shape #(.FRAC_BITS(FRAC_BITS), .FW(FW)) u_shape (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .ctl_in     (ctl1),
    .u          (u1),
    .v          (v1),
    .glyph_kind (glyph_kind),
    .ctl_out    (ctl4),
    .hit        (hit4)
  );

  // output register; non-written results carry zero fields
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= ctl4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      write_pixel  <= hit4;
      opaque       <= hit4 && (weight == ALPHA_FULL);
      pixel_color  <= hit4 ? draw_color : '0;
      blend_weight <= hit4 ? weight : '0;
    end
  end

`ifndef SYNTHESIS
  a_div_stalls: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> pixel_stall)
    else $error("request accepted while reciprocal is being computed");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && write_pixel) |-> (blend_weight != '0 && blend_weight <= ALPHA_FULL))
    else $error("written pixel with bad blend weight");

  a_opaque_written: assert property (@(posedge clk) disable iff (rst)
    (result_valid && opaque) |-> (write_pixel && blend_weight == ALPHA_FULL))
    else $error("opaque flag without a full-weight write");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !write_pixel) |-> (pixel_color == '0 && blend_weight == '0))
    else $error("non-written result carries nonzero fields");
`endif

endmodule
